// File: sv/der_ecdsa_signature_decoder_unit_assert.svh
// assertion macros for the der ecdsa signature decoder checker
`ifndef DER_ECDSA_SIGNATURE_DECODER_UNIT_ASSERT_SVH
`define DER_ECDSA_SIGNATURE_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define DECD_ASSERT_NOW(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet while arst_n is low
`define DECD_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/decd_pkg.sv
// shared constants and types of the der ecdsa signature decoder
package decd_pkg;

	localparam int INT_BYTES = 32;
	localparam int NUM_BYTES = 2 * INT_BYTES;
	localparam int IDX_W     = $clog2(NUM_BYTES);
	localparam int LEN_BITS  = 16;

	localparam logic [7:0] TAG_SEQ   = 8'h30;
	localparam logic [7:0] TAG_INT   = 8'h02;
	localparam logic [6:0] MAX_COUNT = 7'd8;

	// largest accumulator value that still takes another length byte
	localparam logic [LEN_BITS-1:0] ACC_LIMIT =
		LEN_BITS'(((64'd1 << LEN_BITS) - 64'd1) >> 8);

	typedef enum logic [7:0] {
		PH_SEQ_TAG  = 8'b0000_0001,
		PH_SEQ_LEN  = 8'b0000_0010,
		PH_SEQ_LENX = 8'b0000_0100,
		PH_INT_TAG  = 8'b0000_1000,
		PH_INT_LEN  = 8'b0001_0000,
		PH_INT_LENX = 8'b0010_0000,
		PH_INT_BODY = 8'b0100_0000,
		PH_DONE     = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] sig_byte;
		logic [5:0] byte_index;
		logic       ok;
		logic       last;
	} out_item_t;

	// parser to store chain
	typedef struct packed {
		logic clear;
		logic shift;
		logic second;
		logic flush;
		logic ok;
	} store_ctl_t;

	// per-cell controls
	typedef struct packed {
		logic clear;
		logic shift;
		logic flush;
		logic load;
		logic out_shift;
	} cell_ctl_t;

endpackage

// File: sv/der_ecdsa_signature_decoder_unit.sv
// top level of the der ecdsa signature decoder
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in      | input     | in_valid / in_ready    | in_byte, final_byte
//  out     | output    | out_valid / out_ready  | sig_byte, byte_index, ok, last
//
// one input byte per cycle while in_ready is high; the parser and the 64-cell store chain update in that cycle
// the byte marked final copies the store into the output row of the chain in the same cycle
// a good run then gives 64 output transfers, one per cycle while out_ready is high, an error run a single transfer
// a final byte waits (in_ready low) until the last transfer of the previous result
// other bytes keep flowing while results drain, so parsing overlaps output
// reset clears the parser and the output control; the store contents need no reset
module der_ecdsa_signature_decoder_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  decd_pkg::in_item_t    in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output decd_pkg::out_item_t   out_data
);

	decd_pkg::store_ctl_t st;
	logic                 take;
	logic                 out_xfer;
	logic                 busy_q;
	logic                 err_q;
	logic [decd_pkg::IDX_W-1:0] idx_q;
	logic                 out_last;
	logic [7:0]           p_val [decd_pkg::NUM_BYTES];
	logic [7:0]           o_val [decd_pkg::NUM_BYTES];

	// a final byte needs a free output row; the last transfer frees it in the same cycle
	assign in_ready = !(in_data.final_byte && busy_q && !(out_xfer && out_last));
	assign take     = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	decd_parser u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.item  (in_data),
		.ctl   (st)
	);

	// chain of cells: parse row shifts left within a half, output row shifts towards cell 0
	for (genvar k = 0; k < decd_pkg::NUM_BYTES; k++) begin : g_cell
		localparam bit UPPER = (k >= decd_pkg::INT_BYTES);
		localparam bit TAIL  = (k == decd_pkg::INT_BYTES - 1) || (k == decd_pkg::NUM_BYTES - 1);
		decd_pkg::cell_ctl_t cc;
		logic [7:0]          p_in;
		logic [7:0]          o_in;

		assign cc.clear     = st.clear && (st.second == UPPER);
		assign cc.shift     = st.shift && (st.second == UPPER);
		assign cc.flush     = st.flush;
		assign cc.load      = st.flush;
		assign cc.out_shift = out_xfer;

		// the tail cell of each half takes the new body byte
		if (TAIL) begin : g_tail
			assign p_in = in_data.in_byte;
		end else begin : g_body
			assign p_in = p_val[k+1];
		end

		if (k == decd_pkg::NUM_BYTES - 1) begin : g_oend
			assign o_in = 8'h00;
		end else begin : g_omid
			assign o_in = o_val[k+1];
		end

		decd_cell u_cell (
			.clk  (clk),
			.ctl  (cc),
			.p_in (p_in),
			.o_in (o_in),
			.p_val(p_val[k]),
			.o_val(o_val[k])
		);
	end

	// output sequencing
	assign out_last = err_q || (idx_q == decd_pkg::IDX_W'(decd_pkg::NUM_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			err_q  <= 1'b0;
			idx_q  <= '0;
		end else if (st.flush) begin
			busy_q <= 1'b1;
			err_q  <= !st.ok;
			idx_q  <= '0;
		end else if (out_xfer) begin
			if (out_last) busy_q <= 1'b0;
			idx_q <= idx_q + decd_pkg::IDX_W'(1);
		end
	end

	assign out_valid           = busy_q;
	assign out_data.sig_byte   = err_q ? 8'h00 : o_val[0];
	assign out_data.byte_index = err_q ? 6'd0 : 6'(idx_q);
	assign out_data.ok         = !err_q;
	assign out_data.last       = out_last;

endmodule

// File: sv/decd_cell.sv
// one byte cell of the store chain: parse byte and output byte
module decd_cell (
	input  logic                clk,
	input  decd_pkg::cell_ctl_t ctl,
	input  logic [7:0]          p_in,
	input  logic [7:0]          o_in,
	output logic [7:0]          p_val,
	output logic [7:0]          o_val
);

	logic [7:0] p_q;
	logic [7:0] o_q;
	logic [7:0] p_d;

	always_comb begin
		if (ctl.clear) begin
			p_d = 8'h00;
		end else if (ctl.shift) begin
			p_d = p_in;
		end else begin
			p_d = p_q;
		end
	end

	always_ff @(posedge clk) begin
		p_q <= ctl.flush ? 8'h00 : p_d;
		if (ctl.load) begin
			o_q <= p_d;
		end else if (ctl.out_shift) begin
			o_q <= o_in;
		end
	end

	assign p_val = p_q;
	assign o_val = o_q;

endmodule

// File: sv/decd_parser.sv
// der tag and length parser driving the store chain
module decd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  decd_pkg::in_item_t   item,
	output decd_pkg::store_ctl_t ctl
);

	decd_pkg::phase_t phase_q, phase_n;
	logic [decd_pkg::LEN_BITS-1:0] seq_q, seq_n, elem_q, elem_n, acc_q, acc_n;
	logic [decd_pkg::LEN_BITS-1:0] seq_after, len_val;
	logic [3:0] left_q, left_n, left_dec, len_left;
	logic       second_q, second_n, err_q, err_n;
	logic       len_first, len_done, len_err, fin, in_seq, clr_c, shf_c;
	logic [7:0] b;
	logic [6:0] cnt;

	always_comb begin
		b         = item.in_byte;
		cnt       = b[6:0];
		left_dec  = left_q - 4'd1;
		len_first = (phase_q == decd_pkg::PH_SEQ_LEN) || (phase_q == decd_pkg::PH_INT_LEN);
		if (len_first) begin
			len_err  = b[7] && ((cnt == 7'd0) || (cnt > decd_pkg::MAX_COUNT));
			len_done = !b[7];
			len_val  = b[7] ? '0 : decd_pkg::LEN_BITS'(b);
			len_left = b[7] ? cnt[3:0] : left_q;
		end else begin
			len_err  = acc_q > decd_pkg::ACC_LIMIT;
			len_done = (left_dec == 4'd0);
			len_val  = (acc_q << 8) | decd_pkg::LEN_BITS'(b);
			len_left = left_dec;
		end

		in_seq = phase_q inside {decd_pkg::PH_INT_TAG, decd_pkg::PH_INT_LEN,
			decd_pkg::PH_INT_LENX, decd_pkg::PH_INT_BODY};
		seq_after = in_seq ? (seq_q - decd_pkg::LEN_BITS'(1)) : seq_q;

		phase_n  = phase_q;
		seq_n    = seq_q;
		elem_n   = elem_q;
		acc_n    = acc_q;
		left_n   = left_q;
		second_n = second_q;
		err_n    = err_q;
		clr_c    = 1'b0;
		shf_c    = 1'b0;
		fin      = 1'b0;

		if (!err_q && (phase_q != decd_pkg::PH_DONE)) begin
			if (in_seq && (seq_q == '0)) begin
				// tag, length or body byte past the sequence end
				err_n = 1'b1;
			end else begin
				seq_n = seq_after;
				case (phase_q)
					decd_pkg::PH_SEQ_TAG: begin
						if (b != decd_pkg::TAG_SEQ) err_n = 1'b1;
						else phase_n = decd_pkg::PH_SEQ_LEN;
					end
					decd_pkg::PH_SEQ_LEN, decd_pkg::PH_SEQ_LENX: begin
						acc_n  = len_val;
						left_n = len_left;
						if (len_err) begin
							err_n = 1'b1;
						end else if (len_done) begin
							seq_n    = len_val;
							second_n = 1'b0;
							phase_n  = decd_pkg::PH_INT_TAG;
						end else begin
							phase_n = decd_pkg::PH_SEQ_LENX;
						end
					end
					decd_pkg::PH_INT_TAG: begin
						if (b != decd_pkg::TAG_INT) begin
							err_n = 1'b1;
						end else begin
							clr_c   = 1'b1;
							phase_n = decd_pkg::PH_INT_LEN;
						end
					end
					decd_pkg::PH_INT_LEN, decd_pkg::PH_INT_LENX: begin
						acc_n  = len_val;
						left_n = len_left;
						if (len_err) begin
							err_n = 1'b1;
						end else if (len_done) begin
							if (len_val > seq_after) begin
								err_n = 1'b1;
							end else begin
								elem_n = len_val;
								if (len_val == '0) fin = 1'b1;
								else phase_n = decd_pkg::PH_INT_BODY;
							end
						end else begin
							phase_n = decd_pkg::PH_INT_LENX;
						end
					end
					decd_pkg::PH_INT_BODY: begin
						shf_c  = 1'b1;
						elem_n = elem_q - decd_pkg::LEN_BITS'(1);
						if (elem_q == decd_pkg::LEN_BITS'(1)) fin = 1'b1;
					end
					default: begin
						err_n = 1'b1;
					end
				endcase
				if (fin) begin
					if (!second_q) begin
						second_n = 1'b1;
						phase_n  = decd_pkg::PH_INT_TAG;
					end else if (seq_after != '0) begin
						// slack left in the sequence
						err_n = 1'b1;
					end else begin
						phase_n = decd_pkg::PH_DONE;
					end
				end
			end
		end

		ctl.clear  = take && clr_c;
		ctl.shift  = take && shf_c;
		ctl.second = second_q;
		ctl.flush  = take && item.final_byte;
		ctl.ok     = !err_n && (phase_n == decd_pkg::PH_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= decd_pkg::PH_SEQ_TAG;
			seq_q    <= '0;
			elem_q   <= '0;
			acc_q    <= '0;
			left_q   <= '0;
			second_q <= 1'b0;
			err_q    <= 1'b0;
		end else if (take) begin
			if (item.final_byte) begin
				phase_q  <= decd_pkg::PH_SEQ_TAG;
				seq_q    <= '0;
				elem_q   <= '0;
				acc_q    <= '0;
				left_q   <= '0;
				second_q <= 1'b0;
				err_q    <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				seq_q    <= seq_n;
				elem_q   <= elem_n;
				acc_q    <= acc_n;
				left_q   <= left_n;
				second_q <= second_n;
				err_q    <= err_n;
			end
		end
	end

endmodule

// File: sv/decd_checker.sv
// port-level checker for the der ecdsa signature decoder, bound to the top level
`include "der_ecdsa_signature_decoder_unit_assert.svh"

module decd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input decd_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input decd_pkg::out_item_t out_data
);

	`DECD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
	`DECD_ASSERT_NOW(a_err_item, out_valid && !out_data.ok, out_data.last && (out_data.sig_byte == 8'h00) && (out_data.byte_index == 6'd0), "malformed error item")
	`DECD_ASSERT_NEXT(a_idx_step, out_valid && out_ready && out_data.ok && !out_data.last, out_valid && out_data.ok && (out_data.byte_index == 6'($past(out_data.byte_index) + 6'd1)), "result index skipped")
	`DECD_ASSERT_NEXT(a_final_out, in_valid && in_ready && in_data.final_byte, out_valid, "no result after final byte")

endmodule

bind der_ecdsa_signature_decoder_unit decd_checker u_decd_checker (.*);
